// ===== src/swpe_pkg.sv =====
// ============================================================================
// swpe_pkg
// Shared constants and types for the sliding-window peak event counter.
// ============================================================================
`default_nettype none

package swpe_pkg;

    // Default FIFO depth of the window store
    localparam int FIFO_DEPTH_DEF = 1024;

    // Field widths
    localparam int TS_W    = 32;
    localparam int NUM_W   = 32;
    localparam int COUNT_W = 11;

    // Reset value of the window length register (seconds)
    localparam logic [TS_W-1:0] WINDOW_RESET = 32'd60;

    // Input tdata layout: timestamp, is_server_error, zero pad
    localparam int IN_TS_LSB   = 0;
    localparam int IN_ERR_BIT  = 32;
    localparam int IN_DATA_W   = 40;

    // Output tdata layout: window_count, peak_count, peak_start_number,
    // error_count, overflow, zero pad
    localparam int OUT_WIN_LSB   = 0;
    localparam int OUT_PEAK_LSB  = 11;
    localparam int OUT_START_LSB = 22;
    localparam int OUT_ERR_LSB   = 54;
    localparam int OUT_OVF_BIT   = 86;
    localparam int OUT_DATA_W    = 88;

    // Status from the window unit to the top level
    typedef struct packed {
        logic done;      // result ready this cycle
        logic overflow;  // sticky eviction flag
    } t_win_ctl;

endpackage

`default_nettype wire

// ===== src/swpe_ram.sv =====
// ============================================================================
// swpe_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module swpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/swpe_window.sv =====
// ============================================================================
// swpe_window
// Time-window FIFO: pushes each event into the time and number stores,
// then walks the head forward one read per cycle while the head is too old.
// ============================================================================
`default_nettype none

module swpe_window #(
    parameter int FIFO_DEPTH = swpe_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [swpe_pkg::TS_W-1:0]          i_ts,
    input  wire logic [swpe_pkg::NUM_W-1:0]         i_num,
    input  wire logic [swpe_pkg::TS_W-1:0]          i_window,
    input  wire logic                               i_ack,
    output logic                                    o_idle,
    output swpe_pkg::t_win_ctl                      o_ctl,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]         o_occ,
    output logic [swpe_pkg::NUM_W-1:0]              o_head_num
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_OCC  = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] ONE_OCC   = CW'(1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [AW-1:0]              r_head, n_head;
    logic [AW-1:0]              r_tail, n_tail;
    logic [CW-1:0]              r_occ, n_occ;
    logic                       r_ovf, n_ovf;
    logic [swpe_pkg::TS_W-1:0]  r_ts, n_ts;
    logic [swpe_pkg::NUM_W-1:0] r_num, n_num;
    logic [swpe_pkg::NUM_W-1:0] r_head_num, n_head_num;

    logic                       wr_en;
    logic                       done;
    logic [swpe_pkg::NUM_W-1:0] res_num;
    logic [swpe_pkg::TS_W-1:0]  rd_time;
    logic [swpe_pkg::NUM_W-1:0] rd_num;
    logic [swpe_pkg::TS_W-1:0]  age;
    logic                       pop;
    logic                       full;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    // Age of the entry at the head against the current event
    assign age  = r_ts - rd_time;
    assign pop  = (age > i_window);
    assign full = (r_occ == FULL_OCC);

    // Push, scan and hand-off sequencing
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_occ      = r_occ;
        n_ovf      = r_ovf;
        n_ts       = r_ts;
        n_num      = r_num;
        n_head_num = r_head_num;
        wr_en      = 1'b0;
        done       = 1'b0;
        res_num    = r_head_num;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    wr_en  = 1'b1;
                    n_ts   = i_ts;
                    n_num  = i_num;
                    n_tail = next_slot(r_tail);
                    // evict the oldest entry when full, occupancy stays
                    if (full) begin
                        n_head = next_slot(r_head);
                        n_ovf  = 1'b1;
                    end else begin
                        n_occ = r_occ + ONE_OCC;
                    end
                    // the newest entry alone is never popped
                    if (n_occ == ONE_OCC) begin
                        n_head_num = i_num;
                        n_state    = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (pop) begin
                    n_head = next_slot(r_head);
                    n_occ  = r_occ - ONE_OCC;
                    if (n_occ == ONE_OCC) begin
                        done    = 1'b1;
                        res_num = r_num;
                    end
                end else begin
                    done    = 1'b1;
                    res_num = rd_num;
                end
                if (done) begin
                    n_head_num = res_num;
                    n_state    = i_ack ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                done = 1'b1;
                if (i_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_ovf   <= n_ovf;
        end
    end

    // Event payload
    always_ff @(posedge i_clk) begin
        r_ts       <= n_ts;
        r_num      <= n_num;
        r_head_num <= n_head_num;
    end

    // Timestamp store, read at the next head
    swpe_ram #(
        .WIDTH (swpe_pkg::TS_W),
        .DEPTH (FIFO_DEPTH)
    ) u_time_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_ts),
        .i_rd_addr (n_head),
        .o_rd_data (rd_time)
    );

    // Event number store, read at the next head
    swpe_ram #(
        .WIDTH (swpe_pkg::NUM_W),
        .DEPTH (FIFO_DEPTH)
    ) u_num_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_num),
        .i_rd_addr (n_head),
        .o_rd_data (rd_num)
    );

    assign o_idle       = (r_state == ST_IDLE);
    assign o_ctl.done     = done;
    assign o_ctl.overflow = r_ovf;
    assign o_occ        = n_occ;
    assign o_head_num   = res_num;

endmodule

`default_nettype wire

// ===== src/sliding_window_peak_event_count.sv =====
// ============================================================================
// sliding_window_peak_event_count
// Counts events inside a sliding time window and tracks the peak count.
// ============================================================================
// Result: registered once the head walk ends; each head entry read is
//   either popped or, unless only the new event is left, kept as the
//   window start. A new request is taken only while the window unit is
//   idle, so requests do not overlap; the head walk does one store read per
//   cycle on the registered RAM port.
// Reset: synchronous, active low; clears pointers, counters and flags and
//   sets window_seconds to 60. The stores are not cleared (no clearing pass).
// ============================================================================
`default_nettype none

module sliding_window_peak_event_count #(
    parameter int FIFO_DEPTH = swpe_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration: window_seconds
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [swpe_pkg::TS_W-1:0]           i_cfg_wr_data,
    // event requests
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [31:0] timestamp, [32] is_server_error, [39:33] zero
    input  wire logic [swpe_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // results
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [10:0] window_count, [21:11] peak_count, [53:22] peak_start_number,
    // [85:54] error_count, [86] overflow, [87] zero
    output logic [swpe_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [swpe_pkg::TS_W-1:0]       r_window;
    logic [swpe_pkg::NUM_W-1:0]      r_evt, n_evt;
    logic [swpe_pkg::NUM_W-1:0]      r_err;
    logic [CW-1:0]                   r_peak, n_peak;
    logic [swpe_pkg::NUM_W-1:0]      r_peak_start, n_peak_start;
    logic                            r_out_valid;
    logic [swpe_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                            accept;
    logic                            win_idle;
    swpe_pkg::t_win_ctl              win_ctl;
    logic [CW-1:0]                   win_occ;
    logic [swpe_pkg::NUM_W-1:0]      win_head_num;
    logic                            out_free;
    logic                            ack;
    logic                            in_err;

    assign accept   = s_axis_tvalid & s_axis_tready;
    assign in_err   = s_axis_tdata[swpe_pkg::IN_ERR_BIT];
    assign n_evt    = r_evt + 32'd1;
    assign out_free = ~r_out_valid | m_axis_tready;
    assign ack      = win_ctl.done & out_free;

    // Window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= swpe_pkg::WINDOW_RESET;
        end else if (i_cfg_wr_en) begin
            r_window <= i_cfg_wr_data;
        end
    end

    // Event numbering and saturating error count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt <= '0;
            r_err <= '0;
        end else if (accept) begin
            r_evt <= n_evt;
            if (in_err && (r_err != '1)) begin
                r_err <= r_err + 32'd1;
            end
        end
    end

    // Window FIFO and head walk
    swpe_window #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_ts       (s_axis_tdata[swpe_pkg::IN_TS_LSB +: swpe_pkg::TS_W]),
        .i_num      (n_evt),
        .i_window   (r_window),
        .i_ack      (ack),
        .o_idle     (win_idle),
        .o_ctl      (win_ctl),
        .o_occ      (win_occ),
        .o_head_num (win_head_num)
    );

    // Peak update and result assembly
    always_comb begin
        n_peak       = r_peak;
        n_peak_start = r_peak_start;
        if (win_occ > r_peak) begin
            n_peak       = win_occ;
            n_peak_start = win_head_num;
        end
        n_out_data = {1'b0,
                      win_ctl.overflow,
                      r_err,
                      n_peak_start,
                      swpe_pkg::COUNT_W'(n_peak),
                      swpe_pkg::COUNT_W'(win_occ)};
    end

    // Peak state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak       <= '0;
            r_peak_start <= '0;
        end else if (ack) begin
            r_peak       <= n_peak;
            r_peak_start <= n_peak_start;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ack) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ack) begin
            r_out_data <= n_out_data;
        end
    end

    assign s_axis_tready = win_idle;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== src/swpe_checker.sv =====
// ============================================================================
// swpe_checker
// Port-level checks on the sliding-window peak event counter.
// ============================================================================
`default_nettype none

module swpe_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [swpe_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [swpe_pkg::COUNT_W-1:0] win_cnt;
    logic [swpe_pkg::COUNT_W-1:0] peak_cnt;

    assign win_cnt  = m_axis_tdata[swpe_pkg::OUT_WIN_LSB  +: swpe_pkg::COUNT_W];
    assign peak_cnt = m_axis_tdata[swpe_pkg::OUT_PEAK_LSB +: swpe_pkg::COUNT_W];

    // Requests are never accepted back to back
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted in the cycle after an accept");

    // The newest event always stays in the window
    a_window_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (win_cnt != '0))
        else $error("result with an empty window");

    // The peak covers the current window
    a_peak_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (peak_cnt >= win_cnt))
        else $error("peak count below window count");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind sliding_window_peak_event_count swpe_checker u_swpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== sim/sliding_window_peak_event_count_tb.sv =====
// ============================================================================
// sliding_window_peak_event_count_tb
// Self-checking bench for the sliding-window peak event counter. A queue of
// event requests feeds a clocked stream driver; a clocked monitor compares
// every result, field by field, against a behavioral window model kept in
// step with each accepted request and each window length write.
// ============================================================================
`default_nettype none

module sliding_window_peak_event_count_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = swpe_pkg::FIFO_DEPTH_DEF;
    localparam int CALM_START = 1500;
    localparam int CALM_END   = 4500;

    // Expected result of one event
    typedef struct packed {
        logic [swpe_pkg::COUNT_W-1:0] win;
        logic [swpe_pkg::COUNT_W-1:0] peak;
        logic [swpe_pkg::NUM_W-1:0]   start;
        logic [swpe_pkg::NUM_W-1:0]   errs;
        logic                         ovf;
    } t_window_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_wr_en = 1'b0;
    logic [swpe_pkg::TS_W-1:0]       i_cfg_wr_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // [31:0] timestamp, [32] is_server_error, [39:33] zero
    logic [swpe_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [10:0] window_count, [21:11] peak_count, [53:22] peak_start_number,
    // [85:54] error_count, [86] overflow, [87] zero
    logic [swpe_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    sliding_window_peak_event_count #(
        .FIFO_DEPTH(DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Window model state
    logic [swpe_pkg::TS_W-1:0]    model_time [DEPTH];
    logic [swpe_pkg::NUM_W-1:0]   model_num [DEPTH];
    int                           model_head = 0;
    int                           model_tail = 0;
    int                           model_occ = 0;
    int                           model_peak = 0;
    logic [swpe_pkg::NUM_W-1:0]   model_peak_start = '0;
    logic [swpe_pkg::NUM_W-1:0]   model_events = '0;
    logic [swpe_pkg::NUM_W-1:0]   model_errors = '0;
    logic                         model_ovf = 1'b0;
    logic [swpe_pkg::TS_W-1:0]    model_window = swpe_pkg::WINDOW_RESET;

    logic [swpe_pkg::IN_DATA_W-1:0] pending_events [$];
    t_window_result                 expected_results [$];
    int                             n_queued = 0;
    int                             n_checked = 0;
    int                             fail_count = 0;
    int                             cycle_cnt = 0;
    bit                             req_taken = 1'b0;
    logic [swpe_pkg::TS_W-1:0]      cur_ts = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advance the window model by one event
    task automatic predict_window(input logic [swpe_pkg::TS_W-1:0] ts, input logic err,
                                  output t_window_result res);
        model_events = model_events + 1'b1;
        if (err && model_errors != '1)
            model_errors = model_errors + 1'b1;
        // evict the oldest entry when the store is full
        if (model_occ >= DEPTH) begin
            model_head = (model_head + 1) % DEPTH;
            model_occ--;
            model_ovf = 1'b1;
        end
        model_time[model_tail] = ts;
        model_num[model_tail]  = model_events;
        model_tail = (model_tail + 1) % DEPTH;
        model_occ++;
        // drop entries older than the window
        while (model_occ > 0 &&
               (swpe_pkg::TS_W'(ts - model_time[model_head]) > model_window)) begin
            model_head = (model_head + 1) % DEPTH;
            model_occ--;
        end
        if (model_occ > model_peak) begin
            model_peak       = model_occ;
            model_peak_start = model_num[model_head];
        end
        res.win   = swpe_pkg::COUNT_W'(model_occ);
        res.peak  = swpe_pkg::COUNT_W'(model_peak);
        res.start = model_peak_start;
        res.errs  = model_errors;
        res.ovf   = model_ovf;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic bit idle_now();
        return (cycle_cnt < CALM_START || cycle_cnt >= CALM_END) &&
               ($urandom_range(0, 99) < 9);
    endfunction

    // Accept requests into the model and check results
    always @(posedge i_clk) begin
        t_window_result pred;
        t_window_result want;
        t_window_result got;
        if (i_rst_n) begin
            if (i_cfg_wr_en)
                model_window = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_window(s_axis_tdata[swpe_pkg::IN_TS_LSB +: swpe_pkg::TS_W],
                               s_axis_tdata[swpe_pkg::IN_ERR_BIT], pred);
                expected_results.push_back(pred);
                req_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.win   = m_axis_tdata[swpe_pkg::OUT_WIN_LSB +: swpe_pkg::COUNT_W];
                got.peak  = m_axis_tdata[swpe_pkg::OUT_PEAK_LSB +: swpe_pkg::COUNT_W];
                got.start = m_axis_tdata[swpe_pkg::OUT_START_LSB +: swpe_pkg::NUM_W];
                got.errs  = m_axis_tdata[swpe_pkg::OUT_ERR_LSB +: swpe_pkg::NUM_W];
                got.ovf   = m_axis_tdata[swpe_pkg::OUT_OVF_BIT];
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no prediction waiting");
                end else begin
                    want = expected_results.pop_front();
                    if (got.win !== want.win)
                        report_mismatch($sformatf("window_count got %0d want %0d",
                                                  got.win, want.win));
                    if (got.peak !== want.peak)
                        report_mismatch($sformatf("peak_count got %0d want %0d",
                                                  got.peak, want.peak));
                    if (got.start !== want.start)
                        report_mismatch($sformatf("peak_start_number got %0d want %0d",
                                                  got.start, want.start));
                    if (got.errs !== want.errs)
                        report_mismatch($sformatf("error_count got %0d want %0d",
                                                  got.errs, want.errs));
                    if (got.ovf !== want.ovf)
                        report_mismatch($sformatf("overflow got %0b want %0b",
                                                  got.ovf, want.ovf));
                    n_checked++;
                end
            end
        end
    end

    // Drive event requests and result backpressure
    always @(negedge i_clk) begin
        cycle_cnt++;
        if (i_rst_n) begin
            if (!s_axis_tvalid || req_taken) begin
                if (pending_events.size() != 0 && !idle_now()) begin
                    s_axis_tdata  <= pending_events.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            req_taken = 1'b0;
            m_axis_tready <= !idle_now();
        end
    end

    task automatic queue_event(input logic [swpe_pkg::TS_W-1:0] ts, input logic err);
        pending_events.push_back({7'b0, err, ts});
        n_queued++;
        cur_ts = ts;
    endtask

    task automatic wait_drained();
        while (n_checked != n_queued)
            @(negedge i_clk);
    endtask

    // Write the window length once the block is idle
    task automatic write_window(input logic [swpe_pkg::TS_W-1:0] len);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Queue a run of timestamps that mostly move forward, with some noise
    task automatic queue_run(input int count, input int max_step);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 15) == 0)
                queue_event($urandom(), $urandom_range(0, 1));
            else
                queue_event(cur_ts + $urandom_range(0, max_step),
                            $urandom_range(0, 9) < 3);
        end
    endtask

    initial begin
        logic [swpe_pkg::TS_W-1:0] len;
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default window: fill, age out, wrap and go backward in time
        queue_event(32'd0, 1'b0);
        queue_event(32'd0, 1'b1);
        queue_event(32'd30, 1'b0);
        queue_event(32'd60, 1'b1);
        queue_event(32'd61, 1'b0);
        queue_event(32'd200, 1'b1);
        queue_event(32'hFFFF_FFFF, 1'b0);
        queue_event(32'd5, 1'b1);
        queue_event(32'hFFFF_FF00, 1'b0);

        // Zero window: only equal timestamps share the window
        write_window('0);
        queue_event(32'd100, 1'b0);
        queue_event(32'd100, 1'b1);
        queue_event(32'd100, 1'b0);
        queue_event(32'd101, 1'b0);
        queue_event(32'd101, 1'b1);

        // Widest window: nothing ever ages out
        write_window('1);
        queue_event(32'd0, 1'b0);
        queue_event(32'hFFFF_FFFF, 1'b1);
        queue_event(32'h8000_0000, 1'b0);
        queue_event(32'd1, 1'b1);

        // Short windows with mostly forward timestamps
        for (int p = 0; p < 4; p++) begin
            len = $urandom_range(1, 300);
            write_window(len);
            cur_ts = $urandom();
            queue_run(40, len / 8 + 2);
        end

        // Fill past the store depth to force evictions
        write_window('1);
        for (int i = 0; i < 1060; i++)
            queue_event($urandom(), $urandom_range(0, 1));

        // Flush the full store with one event
        write_window('0);
        queue_event(cur_ts + 1'b1, 1'b0);

        // Random full-range windows
        for (int p = 0; p < 2; p++) begin
            write_window($urandom());
            cur_ts = $urandom();
            queue_run(50, 32'h4000_0000);
        end

        wait_drained();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // End the run if it stalls
    initial begin
        #(50_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/swpe_pkg.sv
src/swpe_ram.sv
src/swpe_window.sv
src/sliding_window_peak_event_count.sv
src/swpe_checker.sv
sim/sliding_window_peak_event_count_tb.sv
